// File: hdl/plc_pkg.sv
// Shared types and constants for the password lock controller.
package plc_pkg;

    // status codes sent to the keypad unit
    localparam logic [2:0] CODE_UNMATCHED = 3'd0;
    localparam logic [2:0] CODE_MATCHED   = 3'd1;
    localparam logic [2:0] CODE_OPENED    = 3'd2;
    localparam logic [2:0] CODE_CLOSING   = 3'd3;
    localparam logic [2:0] CODE_CLOSED    = 3'd4;
    localparam logic [2:0] CODE_RESET     = 3'd5;
    localparam logic [2:0] CODE_DONE      = 3'd6;

    // configuration register indexes
    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 8;
    localparam logic [CFG_AW-1:0] CFG_OPEN_TIME    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_HOLD_TIME    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ALARM_TIME   = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX_ATTEMPTS = 2'd3;

    localparam logic [7:0] OPEN_TIME_RST    = 8'd15;
    localparam logic [7:0] HOLD_TIME_RST    = 8'd3;
    localparam logic [7:0] ALARM_TIME_RST   = 8'd60;
    localparam logic [2:0] MAX_ATTEMPTS_RST = 3'd3;

    // result queue
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = 2;
    localparam int unsigned RQ_CW    = 3;

    typedef struct packed {
        logic [7:0] open_time;
        logic [7:0] hold_time;
        logic [7:0] alarm_time;
        logic [2:0] max_attempts;
    } t_cfg;

    typedef struct packed {
        logic [2:0] code;
        logic       motor_on;
        logic       motor_reverse;
        logic       siren_on;
        logic       last;
    } t_res;

    // results caused by one input beat: cnt is 0, 1 or 2
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_emit;

endpackage

// File: hdl/password_lock_controller_unit.sv
// Password lock controller top level: input register, config registers, core, result queue.
// Each input beat (a keypad byte or a one-second tick) is captured in an input register and
// applied to the lock state once the result queue has room for two results; the one or two
// status beats it causes go into that four-entry queue. A beat is taken every cycle as long as
// the queue has room for two results; when every beat causes two results, the rate is set by
// the single output port of the queue. A result passes through the input register and the
// result queue before it is presented on the master side. After reset the block first
// expects two matching password entries of PASSWORD_LEN bytes.
module password_lock_controller_unit #(
    parameter int unsigned PASSWORD_LEN = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    input  logic                         s_axis_tuser,   // [0] req_type
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] tx_valid, [3:1] tx_code, [4] motor_on, [5] motor_reverse, [6] siren_on, [7] zero
    output logic [7:0]                   m_axis_tdata,
    output logic                         m_axis_tlast,   // last_result
    input  logic                         i_cfg_we,
    input  logic [plc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [plc_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import plc_pkg::*;

    logic       r_in_valid;
    logic       r_in_type;
    logic [7:0] r_in_byte;
    t_cfg       r_cfg;
    logic       space2;
    logic       proc_fire;
    t_emit      emit;
    t_res       out_res;

    assign proc_fire     = r_in_valid && space2;
    assign s_axis_tready = !r_in_valid || space2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_type <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_time    <= OPEN_TIME_RST;
            r_cfg.hold_time    <= HOLD_TIME_RST;
            r_cfg.alarm_time   <= ALARM_TIME_RST;
            r_cfg.max_attempts <= MAX_ATTEMPTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OPEN_TIME:    r_cfg.open_time    <= i_cfg_wdata;
                CFG_HOLD_TIME:    r_cfg.hold_time    <= i_cfg_wdata;
                CFG_ALARM_TIME:   r_cfg.alarm_time   <= i_cfg_wdata;
                CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    plc_core #(
        .PASSWORD_LEN (PASSWORD_LEN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (proc_fire),
        .i_req_type (r_in_type),
        .i_rx_byte  (r_in_byte),
        .i_cfg      (r_cfg),
        .o_emit     (emit)
    );

    plc_res_fifo u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (emit),
        .o_space2 (space2),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.siren_on, out_res.motor_reverse, out_res.motor_on,
                           out_res.code, 1'b1};
    assign m_axis_tlast = out_res.last;

endmodule

// File: hdl/plc_core.sv
// Lock state machine: password stores, entry check, attempt counter and timed phases.
module plc_core #(
    parameter int unsigned PASSWORD_LEN = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_req_type,
    input  logic [7:0]      i_rx_byte,
    input  plc_pkg::t_cfg   i_cfg,
    output plc_pkg::t_emit  o_emit
);
    import plc_pkg::*;

    localparam int unsigned IDX_W = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASSWORD_LEN - 1);

    localparam logic [3:0] PH_ENROLL1    = 4'd0;
    localparam logic [3:0] PH_ENROLL2    = 4'd1;
    localparam logic [3:0] PH_IDLE       = 4'd2;
    localparam logic [3:0] PH_CHK_OPEN   = 4'd3;
    localparam logic [3:0] PH_CHK_CHANGE = 4'd4;
    localparam logic [3:0] PH_OPENING    = 4'd5;
    localparam logic [3:0] PH_HOLDING    = 4'd6;
    localparam logic [3:0] PH_CLOSING    = 4'd7;
    localparam logic [3:0] PH_ALARM      = 4'd8;

    localparam logic [7:0] CMD_OPEN   = 8'd0;
    localparam logic [7:0] CMD_CHANGE = 8'd1;

    logic [3:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_mis, n_mis;
    logic [2:0]       r_fails, n_fails;
    logic [7:0]       r_secs, n_secs;
    logic             r_from_chg, n_from_chg;

    logic [7:0] r_stored [PASSWORD_LEN];
    logic [7:0] r_first  [PASSWORD_LEN];

    logic       first_we;
    logic       copy_en;
    logic [7:0] secs_inc;
    logic [7:0] limit;
    logic       tick_done;
    logic       miss;
    logic       mis_acc;
    logic [2:0] fails_inc;

    // drive levels follow the phase at the moment a code is sent
    function automatic t_res res_at(input logic [2:0] code, input logic [3:0] ph);
        t_res r;
        r.code          = code;
        r.motor_on      = (ph == PH_OPENING) || (ph == PH_CLOSING);
        r.motor_reverse = (ph == PH_CLOSING);
        r.siren_on      = (ph == PH_ALARM);
        r.last          = 1'b0;
        return r;
    endfunction

    always_comb begin
        secs_inc = (r_secs != 8'hFF) ? r_secs + 8'd1 : r_secs;
        case (r_phase)
            PH_HOLDING: limit = i_cfg.hold_time;
            PH_ALARM:   limit = i_cfg.alarm_time;
            default:    limit = i_cfg.open_time;
        endcase
        tick_done = (secs_inc >= limit);
        if (r_phase == PH_ENROLL2) begin
            miss = (r_first[r_idx] != i_rx_byte);
        end else begin
            miss = (r_stored[r_idx] != i_rx_byte);
        end
        mis_acc   = r_mis | (miss && (r_phase != PH_ENROLL1));
        fails_inc = r_fails + 3'd1;
    end

    always_comb begin
        t_emit e;
        e          = '0;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_mis      = r_mis;
        n_fails    = r_fails;
        n_secs     = r_secs;
        n_from_chg = r_from_chg;
        first_we   = 1'b0;
        copy_en    = 1'b0;
        if (i_fire) begin
            if (i_req_type) begin
                case (r_phase)
                    PH_OPENING: begin
                        n_secs = tick_done ? 8'd0 : secs_inc;
                        if (tick_done) begin
                            n_phase = PH_HOLDING;
                            e.cnt   = 2'd1;
                            e.r0    = res_at(CODE_OPENED, PH_HOLDING);
                            if (i_cfg.hold_time == 8'd0) begin
                                e.cnt   = 2'd2;
                                e.r1    = res_at(CODE_CLOSING, PH_HOLDING);
                                n_phase = PH_CLOSING;
                            end
                        end
                    end
                    PH_HOLDING: begin
                        n_secs = tick_done ? 8'd0 : secs_inc;
                        if (tick_done) begin
                            e.cnt   = 2'd1;
                            e.r0    = res_at(CODE_CLOSING, PH_HOLDING);
                            n_phase = PH_CLOSING;
                        end
                    end
                    PH_CLOSING: begin
                        n_secs = tick_done ? 8'd0 : secs_inc;
                        if (tick_done) begin
                            n_phase = PH_IDLE;
                            e.cnt   = 2'd1;
                            e.r0    = res_at(CODE_CLOSED, PH_IDLE);
                        end
                    end
                    PH_ALARM: begin
                        n_secs = tick_done ? 8'd0 : secs_inc;
                        if (tick_done) begin
                            n_phase = PH_IDLE;
                            e.cnt   = 2'd1;
                            e.r0    = res_at(CODE_RESET, PH_IDLE);
                        end
                    end
                    default: ;
                endcase
            end else if (r_phase == PH_IDLE) begin
                if (i_rx_byte == CMD_OPEN) begin
                    n_phase = PH_CHK_OPEN;
                    n_idx   = '0;
                    n_mis   = 1'b0;
                end else if (i_rx_byte == CMD_CHANGE) begin
                    n_phase = PH_CHK_CHANGE;
                    n_idx   = '0;
                    n_mis   = 1'b0;
                end
            end else if (r_phase <= PH_CHK_CHANGE) begin
                first_we = (r_phase == PH_ENROLL1);
                if (r_idx != IDX_LAST) begin
                    n_idx = r_idx + IDX_W'(1);
                    n_mis = mis_acc;
                end else begin
                    n_idx = '0;
                    n_mis = 1'b0;
                    if (r_phase == PH_ENROLL1) begin
                        n_phase = PH_ENROLL2;
                    end else if (r_phase == PH_ENROLL2) begin
                        e.cnt = 2'd1;
                        if (mis_acc) begin
                            e.r0    = res_at(CODE_UNMATCHED, PH_ENROLL2);
                            n_phase = PH_ENROLL1;
                        end else begin
                            e.r0    = res_at(CODE_MATCHED, PH_ENROLL2);
                            copy_en = 1'b1;
                            n_phase = PH_IDLE;
                            if (r_from_chg) begin
                                e.cnt      = 2'd2;
                                e.r1       = res_at(CODE_DONE, PH_IDLE);
                                n_from_chg = 1'b0;
                            end
                        end
                    end else if (mis_acc) begin
                        e.cnt = 2'd1;
                        e.r0  = res_at(CODE_UNMATCHED, r_phase);
                        // lockout once the failure count reaches the limit
                        if (fails_inc >= i_cfg.max_attempts) begin
                            n_fails = 3'd0;
                            n_secs  = 8'd0;
                            n_phase = PH_ALARM;
                        end else begin
                            n_fails = fails_inc;
                        end
                    end else begin
                        e.cnt   = 2'd1;
                        e.r0    = res_at(CODE_MATCHED, r_phase);
                        n_fails = 3'd0;
                        if (r_phase == PH_CHK_OPEN) begin
                            n_secs  = 8'd0;
                            n_phase = PH_OPENING;
                        end else begin
                            n_from_chg = 1'b1;
                            n_phase    = PH_ENROLL1;
                        end
                    end
                end
            end
        end
        e.r0.last = (e.cnt == 2'd1);
        e.r1.last = 1'b1;
        o_emit    = e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ENROLL1;
            r_idx      <= '0;
            r_mis      <= 1'b0;
            r_fails    <= 3'd0;
            r_secs     <= 8'd0;
            r_from_chg <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_mis      <= n_mis;
            r_fails    <= n_fails;
            r_secs     <= n_secs;
            r_from_chg <= n_from_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (first_we) begin
            r_first[r_idx] <= i_rx_byte;
        end
        if (copy_en) begin
            r_stored <= r_first;
        end
    end

endmodule

// File: hdl/plc_res_fifo.sv
// Result queue: takes up to two result beats per cycle, sends one per cycle while the receiver is ready.
module plc_res_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plc_pkg::t_emit  i_push,
    output logic            o_space2,
    output logic            o_valid,
    input  logic            i_ready,
    output plc_pkg::t_res   o_data
);
    import plc_pkg::*;

    logic [RQ_AW-1:0] r_wptr;
    logic [RQ_AW-1:0] r_rptr;
    logic [RQ_CW-1:0] r_count;
    t_res             r_mem [RQ_DEPTH];
    logic             pop;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rptr];
    assign pop      = o_valid && i_ready;
    assign o_space2 = (r_count <= RQ_CW'(RQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + RQ_AW'(i_push.cnt);
            r_rptr  <= r_rptr + RQ_AW'(pop);
            r_count <= r_count + RQ_CW'(i_push.cnt) - RQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wptr + RQ_AW'(1)] <= i_push.r1;
        end
    end

endmodule
